[sv/mdcr_pkg.sv]
// Shared constants and controller/datapath interface types for the DC remover.
package mdcr_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int WLEN_W         = 10;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int MAX_WINDOW_DEF = 512;

   // register index within the CSR space (byte address / 4)
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_LENGTH = 1'b0;

   typedef struct packed {
      logic accept;    // capture sample word, issue ring read
      logic bypass;    // zero window: clear mean
      logic update;    // fold sample into ring and running sum
      logic load_div;  // load divider operands
      logic div_step;  // one restoring division step
      logic load_out;  // load result word into output register
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic out_free;
   } status_type;

endpackage

[sv/moving_average_dc_remover_top.sv]
// Top level of the moving-average DC remover: CSR port, sequencer and datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_sample (s16)
//   rsp      out        rsp_valid/rsp_stall  rsp_corrected (s16)
//   csr      in         APB psel/penable     window_length at byte 0
//
// An item passes accept, ring update, divider load, the one-bit-per-cycle
// restoring divide and output; a zero window goes from accept to output.
// One word is in flight; req_stall is high from acceptance until the result
// moves into the output register, which holds it while rsp_stall is high.
// Reset and every window_length write restart the ring fill; no clearing pass.
module moving_average_dc_remover_top #(
   parameter int MAX_WINDOW = mdcr_pkg::MAX_WINDOW_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mdcr_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mdcr_pkg::SAMPLE_W-1:0]   rsp_corrected,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic        [mdcr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic        [mdcr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic        [mdcr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);

   logic [mdcr_pkg::WLEN_W-1:0] window_length_ff;
   logic                        csr_hit;
   logic                        csr_wr;
   mdcr_pkg::cmd_type           cmd;
   mdcr_pkg::status_type        status;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[mdcr_pkg::CSR_ADDR_W-1:2] == mdcr_pkg::REG_WINDOW_LENGTH);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? mdcr_pkg::CSR_DATA_W'(window_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= '0;
      end else if (csr_wr) begin
         window_length_ff <= csr_pwdata[mdcr_pkg::WLEN_W-1:0];
      end
   end

   mdcr_ctrl #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mdcr_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg_clear     (csr_wr),
      .window_length (window_length_ff),
      .req_sample    (req_sample),
      .cmd           (cmd),
      .status        (status),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_corrected (rsp_corrected)
   );

endmodule

[sv/mdcr_ram.sv]
// Generic single-port-write, registered-read RAM.
module mdcr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mdcr_ctrl.sv]
// Sequencer for the DC remover: accept, ring update, divide, output.
module mdcr_ctrl #(
   parameter int MAX_WINDOW = mdcr_pkg::MAX_WINDOW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mdcr_pkg::status_type status,
   output mdcr_pkg::cmd_type    cmd
);

   localparam int DIV_STEPS = mdcr_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_OUTPUT = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             take;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.accept = 1'b1;
               if (status.len_zero) begin
                  cmd.bypass = 1'b1;
                  state_in   = ST_OUTPUT;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // hold until the output register can take the word
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[sv/mdcr_datapath.sv]
// Datapath: sample ring, running sum, restoring divider and saturating output.
module mdcr_datapath #(
   parameter int MAX_WINDOW = mdcr_pkg::MAX_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cfg_clear,
   input  logic        [mdcr_pkg::WLEN_W-1:0]   window_length,
   input  logic signed [mdcr_pkg::SAMPLE_W-1:0] req_sample,
   input  mdcr_pkg::cmd_type                    cmd,
   output mdcr_pkg::status_type                 status,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [mdcr_pkg::SAMPLE_W-1:0] rsp_corrected
);

   localparam int SW     = mdcr_pkg::SAMPLE_W;
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = SW + SLOT_W;

   localparam logic signed [SUM_W:0] SAT_HI = (SUM_W + 1)'((1 << (SW - 1)) - 1);
   localparam logic signed [SUM_W:0] SAT_LO = -(SUM_W + 1)'(1 << (SW - 1));

   logic signed [SW-1:0]    sample_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic                    full_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [LEN_W-1:0]        div_ff;
   logic [LEN_W-1:0]        rem_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    rsp_corrected_ff;

   logic [LEN_W-1:0]        eff_len;
   logic [SLOT_W-1:0]       slot_fix;
   logic [LEN_W-1:0]        slot_inc;
   logic                    wrap;
   logic [SW-1:0]           old_word;
   logic signed [SUM_W-1:0] old_term;
   logic signed [SUM_W-1:0] sum_next;
   logic [LEN_W:0]          trial;
   logic                    trial_ge;
   logic [LEN_W:0]          trial_sub;
   logic signed [SUM_W-1:0] mean;
   logic signed [SUM_W:0]   diff;
   logic signed [SW-1:0]    diff_sat;

   // clip the window to the ring depth
   assign eff_len = (32'(window_length) > 32'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW)
                                                          : LEN_W'(window_length);
   assign slot_fix = (LEN_W'(slot_ff) >= eff_len) ? '0 : slot_ff;
   assign slot_inc = LEN_W'(slot_ff) + 1'b1;
   assign wrap     = (slot_inc == eff_len);

   mdcr_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (slot_fix),
      .rd_data (old_word)
   );

   assign old_term = full_ff ? SUM_W'(signed'(old_word)) : '0;
   assign sum_next = sum_ff - old_term + SUM_W'(sample_ff);

   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge  = (trial >= {1'b0, div_ff});
   assign trial_sub = trial - {1'b0, div_ff};

   assign mean = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);
   assign diff = (SUM_W + 1)'(sample_ff) - (SUM_W + 1)'(mean);

   always_comb begin
      if (diff > SAT_HI) begin
         diff_sat = SW'(SAT_HI);
      end else if (diff < SAT_LO) begin
         diff_sat = SW'(SAT_LO);
      end else begin
         diff_sat = diff[SW-1:0];
      end
   end

   assign status.len_zero = (eff_len == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // ring control state
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         slot_ff <= '0;
         full_ff <= 1'b0;
         sum_ff  <= '0;
      end else if (cmd.accept && !status.len_zero) begin
         slot_ff <= slot_fix;
      end else if (cmd.update) begin
         sum_ff  <= sum_next;
         slot_ff <= wrap ? '0 : slot_inc[SLOT_W-1:0];
         full_ff <= full_ff || wrap;
      end
   end

   // sample, divider operands and quotient
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.bypass) begin
         quo_ff <= '0;
         neg_ff <= 1'b0;
      end else if (cmd.update) begin
         div_ff <= (full_ff || wrap) ? eff_len : slot_inc;
      end else if (cmd.load_div) begin
         neg_ff <= sum_ff[SUM_W-1];
         quo_ff <= sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], trial_ge};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_corrected_ff <= diff_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corrected = rsp_corrected_ff;

endmodule
